// ===== sv/pcm_to_wav_stream_encoder_unit_assert.svh =====
// Assertion macros for the WAV stream encoder checker.
// No dependencies; included by the checker file.
`ifndef PCM_TO_WAV_STREAM_ENCODER_UNIT_ASSERT_SVH
`define PCM_TO_WAV_STREAM_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define PWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated off during reset.
`define PWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication checked through reset as well.
`define PWE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pwe_pkg.sv =====
// Shared types, constants and the header byte table of the WAV stream encoder.
// No dependencies.
package pwe_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int HDR_BYTES = 44;
  localparam logic [5:0] POS_LO = 6'd44;
  localparam logic [5:0] POS_HI = 6'd45;

  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_SPF   = 2'd1;
  localparam logic [1:0] REG_FLOAT = 2'd2;

  localparam logic [30:0] RATE_RST  = 31'd16000;
  localparam logic [30:0] SPF_RST   = 31'd1;
  localparam logic        FLOAT_RST = 1'b1;

  typedef struct packed {
    logic [15:0] pcm;
    logic        hdr;   // header goes out ahead of this sample
    logic        last;  // sample closes the file
  } pwe_item_t;

  // Byte at position pos (0..43) of the 44-byte RIFF header.
  function automatic logic [7:0] hdr_byte(input logic [5:0] pos,
                                          input logic [30:0] rate,
                                          input logic [30:0] spf);
    logic [31:0] dsz;
    logic [31:0] rsz;
    logic [31:0] brate;
    logic [31:0] r32;
    logic [7:0]  b;
    dsz   = {spf, 1'b0};
    rsz   = dsz + 32'd36;
    brate = {rate, 1'b0};
    r32   = {1'b0, rate};
    case (pos)
      6'd0:  b = 8'h52;
      6'd1:  b = 8'h49;
      6'd2:  b = 8'h46;
      6'd3:  b = 8'h46;
      6'd4:  b = rsz[7:0];
      6'd5:  b = rsz[15:8];
      6'd6:  b = rsz[23:16];
      6'd7:  b = rsz[31:24];
      6'd8:  b = 8'h57;
      6'd9:  b = 8'h41;
      6'd10: b = 8'h56;
      6'd11: b = 8'h45;
      6'd12: b = 8'h66;
      6'd13: b = 8'h6d;
      6'd14: b = 8'h74;
      6'd15: b = 8'h20;
      6'd16: b = 8'h10;
      6'd20: b = 8'h01;
      6'd22: b = 8'h01;
      6'd24: b = r32[7:0];
      6'd25: b = r32[15:8];
      6'd26: b = r32[23:16];
      6'd27: b = r32[31:24];
      6'd28: b = brate[7:0];
      6'd29: b = brate[15:8];
      6'd30: b = brate[23:16];
      6'd31: b = brate[31:24];
      6'd32: b = 8'h02;
      6'd34: b = 8'h10;
      6'd36: b = 8'h64;
      6'd37: b = 8'h61;
      6'd38: b = 8'h74;
      6'd39: b = 8'h61;
      6'd40: b = dsz[7:0];
      6'd41: b = dsz[15:8];
      6'd42: b = dsz[23:16];
      6'd43: b = dsz[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/pwe_queue.sv =====
// Short register queue between front and back of the WAV stream encoder.
// Depends on pwe_pkg.
module pwe_queue
  import pwe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pwe_item_t push_item,
  input  logic      pop,
  output pwe_item_t head,
  output logic      empty,
  output logic      full
);

  pwe_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QDEPTH));
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

// ===== sv/pwe_front.sv =====
// Front end: takes samples, converts to PCM16 and tracks file position.
// Depends on pwe_pkg.
module pwe_front
  import pwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_word,
  input  logic [30:0] samples_per_file,
  input  logic        float_input_mode,
  input  logic        q_full,
  output logic        push,
  output pwe_item_t   push_item
);

  logic        header_pending;
  logic [30:0] samples_done;

  logic        sgn;
  logic [7:0]  ex;
  logic [23:0] man;
  logic [38:0] prod;
  logic [23:0] kept;
  logic        grd;
  logic        stk;
  logic [24:0] rnd;
  logic [8:0]  esum;
  logic [8:0]  nsh;
  logic [24:0] mag;
  logic        sat;
  logic        zero;
  logic [15:0] fpcm;
  logic        last;

  // float x 32767, round to nearest even at 24 bits, truncate toward zero
  always_comb begin
    sgn  = sample_word[31];
    ex   = sample_word[30:23];
    man  = {1'b1, sample_word[22:0]};
    prod = 39'(man) * 39'd32767;
    if (prod[38]) begin
      kept = prod[38:15];
      grd  = prod[14];
      stk  = |prod[13:0];
      esum = {1'b0, ex} + 9'd15;
    end else begin
      kept = prod[37:14];
      grd  = prod[13];
      stk  = |prod[12:0];
      esum = {1'b0, ex} + 9'd14;
    end
    rnd  = {1'b0, kept} + 25'(grd && (stk || kept[0]));
    nsh  = 9'd150 - esum;
    mag  = (nsh >= 9'd25) ? 25'd0 : (rnd >> nsh[4:0]);
    zero = (ex == 8'd0) || ((ex == 8'hFF) && (sample_word[22:0] != '0));
    sat  = (ex == 8'hFF) || (esum >= 9'd150) || (mag[24:15] != '0);
    if (zero) begin
      fpcm = 16'h0000;
    end else if (sat) begin
      fpcm = sgn ? 16'h8000 : 16'h7FFF;
    end else begin
      fpcm = sgn ? (16'h0000 - mag[15:0]) : mag[15:0];
    end
  end

  assign last     = ({1'b0, samples_done} + 32'd1) >= {1'b0, samples_per_file};
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign push_item.pcm  = float_input_mode ? fpcm : sample_word[15:0];
  assign push_item.hdr  = header_pending;
  assign push_item.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pending <= 1'b1;
      samples_done   <= '0;
    end else if (push) begin
      if (last) begin
        header_pending <= 1'b1;
        samples_done   <= '0;
      end else begin
        header_pending <= 1'b0;
        samples_done   <= samples_done + 1'b1;
      end
    end
  end

endmodule

// ===== sv/pwe_back.sv =====
// Back end: walks header and sample bytes of each queued item onto the byte stream.
// Depends on pwe_pkg.
module pwe_back
  import pwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pwe_item_t   head,
  input  logic        q_empty,
  output logic        pop,
  input  logic [30:0] sample_rate_hz,
  input  logic [30:0] samples_per_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_header,
  output logic        last_byte
);

  logic [5:0] idx;
  logic [5:0] pos;
  logic       load;

  assign load = !out_valid || out_ready;
  assign pos  = head.hdr ? idx : idx + POS_LO;
  assign pop  = load && !q_empty && (pos == POS_HI);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= (pos == POS_HI) ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (pos < POS_LO) begin
        out_byte  <= hdr_byte(pos, sample_rate_hz, samples_per_file);
        is_header <= 1'b1;
        last_byte <= 1'b0;
      end else if (pos == POS_LO) begin
        out_byte  <= head.pcm[7:0];
        is_header <= 1'b0;
        last_byte <= 1'b0;
      end else begin
        out_byte  <= head.pcm[15:8];
        is_header <= 1'b0;
        last_byte <= head.last;
      end
    end
  end

endmodule

// ===== sv/pcm_to_wav_stream_encoder_unit.sv =====
// Top level of the mono 16-bit WAV stream encoder: registers, front, queue, back.
// Depends on pwe_pkg, pwe_front, pwe_queue and pwe_back.
//
// Takes one sample per input transfer (IEEE single bits scaled by 32767, or an
// int16 in the low half) and produces a byte stream of WAV files: a 44-byte
// RIFF header before the first sample of each file, then two little-endian
// bytes per sample, with last_byte on the high byte of the file's final
// sample. Each sample costs two output transfers, 46 when it opens a file,
// and the byte-wide output register of the back end sets that pace. The
// front converts a sample in the cycle it is taken and parks it in a
// two-entry queue, so input transfers continue while the back end is busy or
// stalled, until the queue is full. Header fields use the register values
// at the time the header bytes leave; registers should only be written while
// the block is idle.
module pcm_to_wav_stream_encoder_unit
  import pwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_header,
  output logic        last_byte
);

  logic [30:0] sample_rate_hz;
  logic [30:0] samples_per_file;
  logic        float_input_mode;

  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;
  pwe_item_t push_item;
  pwe_item_t head;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz   <= RATE_RST;
      samples_per_file <= SPF_RST;
      float_input_mode <= FLOAT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RATE:  sample_rate_hz   <= cfg_data;
        REG_SPF:   samples_per_file <= cfg_data;
        REG_FLOAT: float_input_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pwe_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample_word      (sample_word),
    .samples_per_file (samples_per_file),
    .float_input_mode (float_input_mode),
    .q_full           (q_full),
    .push             (push),
    .push_item        (push_item)
  );

  pwe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  pwe_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .sample_rate_hz   (sample_rate_hz),
    .samples_per_file (samples_per_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .is_header        (is_header),
    .last_byte        (last_byte)
  );

endmodule

// ===== sv/pwe_checker.sv =====
// Port-level checks on the WAV stream encoder, bound to the top level.
// Depends on pcm_to_wav_stream_encoder_unit_assert.svh.
`include "pcm_to_wav_stream_encoder_unit_assert.svh"

module pwe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_header,
  input logic       last_byte
);

  `PWE_ASSERT_RST(a_rst_idle, rst, !out_valid, "output valid straight after reset")
  `PWE_ASSERT_NEXT(a_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte), "stalled byte dropped")
  `PWE_ASSERT_NOW(a_last_data, out_valid && last_byte, !is_header, "last flag on a header byte")
  `PWE_ASSERT_NEXT(a_new_file, out_valid && out_ready && last_byte,
                   !out_valid || is_header, "file not opened by header")

endmodule

bind pcm_to_wav_stream_encoder_unit pwe_checker u_pwe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .is_header (is_header),
  .last_byte (last_byte)
);

// ===== test/pcm_to_wav_stream_encoder_unit_tb.sv =====
// Self-checking testbench for the mono 16-bit WAV stream encoder.
// Depends on pwe_pkg and pcm_to_wav_stream_encoder_unit.
module pcm_to_wav_stream_encoder_unit_tb;
  import pwe_pkg::*;

  // Expected byte of the output stream
  typedef struct {
    logic [7:0] byte_val;
    logic       hdr;
    logic       last;
  } wav_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_RATE;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] sample_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        is_header;
  logic        last_byte;

  // Local copy of the block's registers and file state
  logic [30:0] rate_m = RATE_RST;
  logic [30:0] spf_m = SPF_RST;
  logic        float_m = FLOAT_RST;
  logic        hdr_due_m = 1'b1;
  logic [30:0] done_m = '0;

  wav_byte_t wav_bytes_q[$];
  int errors = 0;
  int samples_sent = 0;
  int bytes_checked = 0;
  int files_closed = 0;
  int idle_cycles = 0;

  // Sender burst/gap control and receiver stall pattern
  bit tx_gaps = 1'b0;
  int tx_burst = 0;
  int rx_mode = 0;
  int rx_run = 0;
  bit rx_level = 1'b1;

  pcm_to_wav_stream_encoder_unit uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_word(sample_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .is_header(is_header), .last_byte(last_byte)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  // Single-precision x*32767 with round-to-nearest-even, clamped and truncated,
  // done in integer arithmetic so the host's float width does not matter.
  function automatic logic [15:0] scale_to_pcm(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  ex;
    logic [63:0] p, q, rem, half, mag;
    int          e2, msb, sh;
    sgn = f[31];
    ex = f[30:23];
    if (ex == 8'hFF) begin
      if (f[22:0] != 0) return 16'h0000;          // NaN
      return sgn ? 16'h8000 : 16'h7FFF;           // infinities clamp
    end
    if (ex == 0) begin
      p = {41'd0, f[22:0]};
      e2 = -149;
    end else begin
      p = {40'd0, 1'b1, f[22:0]};
      e2 = int'(ex) - 150;
    end
    p = p * 64'd32767;
    if (p == 0) return 16'h0000;
    msb = 0;
    for (int i = 0; i < 64; i++) if (p[i]) msb = i;
    q = p;
    if (msb > 23) begin
      sh = msb - 23;
      q = p >> sh;
      rem = p & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (q == (64'd1 << 24)) begin
        q = q >> 1;
        sh = sh + 1;
      end
      e2 = e2 + sh;
    end
    if (e2 >= 16) mag = 64'd65536;
    else if (e2 >= 0) mag = q << e2;
    else if (e2 <= -40) mag = 0;
    else mag = q >> (-e2);
    if (!sgn) return (mag > 32767) ? 16'h7FFF : mag[15:0];
    if (mag >= 32768) return 16'h8000;
    return 16'(-int'(mag));
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic h, input logic l);
    wav_byte_t e;
    e.byte_val = b;
    e.hdr = h;
    e.last = l;
    wav_bytes_q.push_back(e);
  endfunction

  function automatic void push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8], 1'b1, 1'b0);
  endfunction

  // Expected bytes caused by one accepted sample
  function automatic void predict_wav_bytes(input logic [31:0] w);
    logic [31:0] dsz;
    logic [15:0] pcm;
    logic        fin;
    if (hdr_due_m) begin
      dsz = {spf_m, 1'b0};
      push_le(32'h4646_4952, 4);               // "RIFF"
      push_le(dsz + 32'd36, 4);
      push_le(32'h4556_4157, 4);               // "WAVE"
      push_le(32'h2074_6d66, 4);               // "fmt "
      push_le(32'd16, 4);
      push_le(32'd1, 2);
      push_le(32'd1, 2);
      push_le({1'b0, rate_m}, 4);
      push_le({rate_m, 1'b0}, 4);
      push_le(32'd2, 2);
      push_le(32'd16, 2);
      push_le(32'h6174_6164, 4);               // "data"
      push_le(dsz, 4);
      hdr_due_m = 1'b0;
    end
    pcm = float_m ? scale_to_pcm(w) : w[15:0];
    fin = ({1'b0, done_m} + 32'd1) >= {1'b0, spf_m};
    push_byte(pcm[7:0], 1'b0, 1'b0);
    push_byte(pcm[15:8], 1'b0, fin);
    if (fin) begin
      done_m = '0;
      hdr_due_m = 1'b1;
    end else begin
      done_m = done_m + 1;
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  // Stall pattern: always ready, random 3-in-4, or runs of random length
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (rx_run == 0) begin
            rx_run <= $urandom_range(1, 12);
            rx_level <= ~rx_level;
          end else begin
            rx_run <= rx_run - 1;
          end
          out_ready <= rx_level;
        end
      endcase
    end
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    wav_byte_t e;
    if (!rst && out_valid && out_ready) begin
      if (wav_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte %02h hdr %0b last %0b", $time, out_byte,
                 is_header, last_byte);
        errors++;
      end else begin
        e = wav_bytes_q.pop_front();
        bytes_checked++;
        if (last_byte) files_closed++;
        if (out_byte !== e.byte_val || is_header !== e.hdr || last_byte !== e.last) begin
          $display("%0t: expected byte %02h hdr %0b last %0b, got %02h hdr %0b last %0b",
                   $time, e.byte_val, e.hdr, e.last, out_byte, is_header, last_byte);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sender
  // One input transfer; valid stays high into the next item unless a gap falls
  task automatic send_sample(input logic [31:0] w);
    in_valid <= 1'b1;
    sample_word <= w;
    do @(posedge clk); while (!in_ready);
    predict_wav_bytes(w);
    samples_sent++;
    if (tx_burst > 0) begin
      tx_burst--;
    end else begin
      tx_burst = $urandom_range(1, 10);
      if (tx_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every expected byte, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wav_bytes_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Writes all three registers plus an out-of-range index that must be ignored
  task automatic set_regs(input logic [30:0] rate, input logic [30:0] spf,
                          input logic fm);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_index <= REG_SPF;
    cfg_data <= spf;
    @(posedge clk);
    cfg_index <= REG_FLOAT;
    cfg_data <= {30'h2AAA_AAAA, fm};
    @(posedge clk);
    cfg_index <= 2'd3;
    cfg_data <= 31'h7FFF_FFFF;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rate_m = rate;
    spf_m = spf;
    float_m = fm;
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {1'($urandom()), 8'($urandom_range(100, 126)), 23'($urandom())};
      2: return {1'($urandom()), 8'($urandom_range(126, 127)), 23'($urandom())};
      3: return {1'($urandom()), 8'($urandom_range(127, 150)), 23'($urandom())};
      4: return {1'($urandom()), 8'hFF, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom()))};
      default: return {1'($urandom()), 8'd0, 23'($urandom())};
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  // Reset values: one-sample files at 16 kHz, float input, specials
  task automatic test_float_specials();
    logic [31:0] v[13] = '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
                           32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'h3F00_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'hBF7F_FFFF,
                           32'h3EFF_FF00};
    foreach (v[i]) send_sample(v[i]);
    drain();
  endtask

  // Int passthrough with zero rate and zero file length
  task automatic test_int_extremes();
    set_regs(31'd0, 31'd0, 1'b0);
    send_sample(32'h0000_8000);
    send_sample(32'hFFFF_7FFF);
    send_sample(32'h1234_ABCD);
    send_sample(32'hFFFF_FFFF);
    drain();
  endtask

  // Largest rate and file length; file left open, then closed by a short length
  task automatic test_size_extremes();
    set_regs(31'h7FFF_FFFF, 31'd2147483629, 1'b0);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h5555_AAAA);
    drain();
    set_regs(31'd44100, 31'd1, 1'b1);
    send_sample(32'h3F40_0000);
    drain();
  endtask

  // Random phases: registers, idling and stalls change per phase
  task automatic test_random_phases();
    logic [30:0] spf;
    for (int ph = 0; ph < 6; ph++) begin
      rx_mode = ph % 3;
      tx_gaps = (ph % 2 == 1);
      spf = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 40)) :
                                          31'($urandom_range(1, 6));
      set_regs(31'($urandom()), spf, 1'($urandom()));
      for (int i = 0; i < 75; i++) begin
        // in phase 2 the sender holds off once mid-phase until the stream is empty
        if (ph == 2 && i == 30) drain();
        send_sample(float_m ? rand_float() : $urandom());
      end
      drain();
    end
    // closing phase back at the reset-like extreme of one sample per file
    rx_mode = 2;
    tx_gaps = 1'b1;
    set_regs(31'd1, 31'd1, 1'b1);
    for (int i = 0; i < 20; i++) send_sample(rand_float());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_float_specials();
    test_int_extremes();
    test_size_extremes();
    test_random_phases();
    $display("covered %0d samples, %0d bytes checked, %0d files closed", samples_sent,
             bytes_checked, files_closed);
    $display("float and int input, header sizes at both extremes, idle/stall mixes");
    if (errors == 0 && wav_bytes_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
